// File: design/dsdl_pkg.sv
// ----------------------------------------------------------------------------
// dsdl_pkg
// Shared types and codes of the distance sorted draw list: request and
// response payloads, stored entry and cell control groups.
// ----------------------------------------------------------------------------
package dsdl_pkg;

   localparam int TYPE_W  = 3;
   localparam int INDEX_W = 15;
   localparam int DIST_W  = 32;
   localparam int FLAGS_W = 8;
   localparam int POS_W   = 10;
   localparam int MODE_W  = 2;
   localparam int COUNT_OUT_W = 11;

   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;
   localparam logic [MODE_W-1:0] MODE_READ   = 2'd3;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [TYPE_W-1:0]  item_kind;
      logic [INDEX_W-1:0] item_index;
      logic [DIST_W-1:0]  distance;
      logic [FLAGS_W-1:0] item_flags;
      logic [POS_W-1:0]   position;
   } req_type;

   typedef struct packed {
      logic                   accepted;
      logic                   found;
      logic [COUNT_OUT_W-1:0] entry_count;
      logic                   read_valid;
      logic [TYPE_W-1:0]      read_kind;
      logic [INDEX_W-1:0]     read_index;
      logic [DIST_W-1:0]      read_distance;
      logic [FLAGS_W-1:0]     read_flags;
   } rsp_type;

   typedef struct packed {
      logic [TYPE_W-1:0]  item_kind;
      logic [INDEX_W-1:0] item_index;
      logic [DIST_W-1:0]  distance;
      logic [FLAGS_W-1:0] item_flags;
   } entry_type;

   typedef struct packed {
      logic      hit;
      entry_type entry;
   } probe_type;

   typedef struct packed {
      logic insert;
      logic probe;
   } cell_ctrl_type;

endpackage

// File: design/distance_sorted_draw_list.sv
// ----------------------------------------------------------------------------
// distance_sorted_draw_list
// Bounded list of render items kept in ascending distance order in a row of
// cells; supports clear, insert, lookup by type and index, read by position.
//
//   channel   direction   ports                              payload
//   request   in          req_valid, req_stall, req_data     req_type
//   response  out         rsp_valid, rsp_stall, rsp_data     rsp_type
//
// clear and insert: response registered at the accept edge
// lookup and read: response registered after the probe capture in the cells
//    and the registered levels of the OR tree
// one request in flight; a new request is taken once the response leaves
// reset empties the list and the response register
// ----------------------------------------------------------------------------
module distance_sorted_draw_list #(
   parameter int LIST_DEPTH = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dsdl_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dsdl_pkg::rsp_type rsp_data
);
   import dsdl_pkg::*;

   localparam int COUNT_W  = $clog2(LIST_DEPTH + 1);
   localparam int LEVELS   = ($clog2(LIST_DEPTH) + 1) / 2 > 0 ?
                             ($clog2(LIST_DEPTH) + 1) / 2 : 1;
   localparam int WAIT_W   = $clog2(LEVELS + 1);
   localparam int PROBE_W  = $bits(probe_type);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [WAIT_W-1:0]  wait_ff, wait_in;
   logic               pending_ff, pending_in;
   logic               lookup_ff, lookup_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               accept;
   logic               full;
   cell_ctrl_type      ctrl;
   logic               gt [LIST_DEPTH];
   entry_type          entry [LIST_DEPTH];
   logic [PROBE_W-1:0] probe [LIST_DEPTH];
   logic [PROBE_W-1:0] root;
   probe_type          result;

   assign req_stall = pending_ff || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign full      = count_ff == COUNT_W'(LIST_DEPTH);

   assign ctrl.insert = accept && (req_data.mode == MODE_INSERT) && !full;
   assign ctrl.probe  = accept && ((req_data.mode == MODE_LOOKUP)
                                   || (req_data.mode == MODE_READ));

   for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
      probe_type cell_probe;
      if (i == 0) begin : g_head
         dsdl_cell #(.CELL_ID(i), .COUNT_W(COUNT_W)) u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .req        (req_data),
            .count      (count_ff),
            .prev_gt    (1'b0),
            .prev_entry ('0),
            .gt         (gt[i]),
            .entry      (entry[i]),
            .probe      (cell_probe)
         );
      end else begin : g_body
         dsdl_cell #(.CELL_ID(i), .COUNT_W(COUNT_W)) u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .req        (req_data),
            .count      (count_ff),
            .prev_gt    (gt[i-1]),
            .prev_entry (entry[i-1]),
            .gt         (gt[i]),
            .entry      (entry[i]),
            .probe      (cell_probe)
         );
      end
      assign probe[i] = cell_probe;
   end

   dsdl_or_tree #(.LEAVES(LIST_DEPTH), .WIDTH(PROBE_W)) u_tree (
      .clock (clock),
      .leaf  (probe),
      .root  (root)
   );

   assign result = root;

   always_comb begin
      count_in     = count_ff;
      wait_in      = wait_ff;
      pending_in   = pending_ff;
      lookup_in    = lookup_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (pending_ff) begin
         if (wait_ff == '0) begin
            pending_in            = 1'b0;
            rsp_valid_in          = 1'b1;
            rsp_in                = '0;
            rsp_in.entry_count    = COUNT_OUT_W'(count_ff);
            if (lookup_ff) begin
               rsp_in.found = result.hit;
            end else begin
               rsp_in.read_valid    = result.hit;
               rsp_in.read_kind     = result.entry.item_kind;
               rsp_in.read_index    = result.entry.item_index;
               rsp_in.read_distance = result.entry.distance;
               rsp_in.read_flags    = result.entry.item_flags;
            end
         end else begin
            wait_in = wait_ff - 1'b1;
         end
      end else if (accept) begin
         rsp_in = '0;
         unique case (req_data.mode)
            MODE_CLEAR: begin
               count_in           = '0;
               rsp_valid_in       = 1'b1;
               rsp_in.entry_count = '0;
            end
            MODE_INSERT: begin
               if (!full) begin
                  count_in        = count_ff + 1'b1;
                  rsp_in.accepted = 1'b1;
               end
               rsp_valid_in       = 1'b1;
               rsp_in.entry_count = COUNT_OUT_W'(count_in);
            end
            MODE_LOOKUP, MODE_READ: begin
               pending_in = 1'b1;
               wait_in    = WAIT_W'(LEVELS);
               lookup_in  = req_data.mode == MODE_LOOKUP;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         wait_ff      <= '0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         wait_ff      <= wait_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lookup_ff <= lookup_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: design/dsdl_cell.sv
// ----------------------------------------------------------------------------
// dsdl_cell
// One slot of the sorted list. Compares its key against a new request,
// shifts its neighbor's entry in on insert and captures a probe hit.
// ----------------------------------------------------------------------------
module dsdl_cell #(
   parameter int CELL_ID = 0,
   parameter int COUNT_W = 11
) (
   input  logic                  clock,
   input  dsdl_pkg::cell_ctrl_type ctrl,
   input  dsdl_pkg::req_type     req,
   input  logic [COUNT_W-1:0]    count,
   input  logic                  prev_gt,
   input  dsdl_pkg::entry_type   prev_entry,
   output logic                  gt,
   output dsdl_pkg::entry_type   entry,
   output dsdl_pkg::probe_type   probe
);
   import dsdl_pkg::*;

   localparam logic REACHABLE = CELL_ID < (1 << POS_W);

   entry_type entry_ff, entry_in;
   probe_type probe_ff, probe_in;
   entry_type new_entry;
   logic      occupied;
   logic      hit;

   assign occupied = COUNT_W'(CELL_ID) < count;
   assign gt       = !occupied || (entry_ff.distance > req.distance);

   assign new_entry.item_kind  = req.item_kind;
   assign new_entry.item_index = req.item_index;
   assign new_entry.distance   = req.distance;
   assign new_entry.item_flags = req.item_flags;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert) begin
         priority if (prev_gt) begin
            entry_in = prev_entry;
         end else if (gt) begin
            entry_in = new_entry;
         end else begin
            entry_in = entry_ff;
         end
      end
   end

   always_comb begin
      if (req.mode == MODE_LOOKUP) begin
         hit = occupied && (entry_ff.item_kind == req.item_kind)
               && (entry_ff.item_index == req.item_index);
      end else begin
         hit = occupied && REACHABLE && (req.position == POS_W'(CELL_ID));
      end
      probe_in.hit   = hit;
      probe_in.entry = hit ? entry_ff : '0;
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (ctrl.probe) begin
         probe_ff <= probe_in;
      end
   end

   assign entry = entry_ff;
   assign probe = probe_ff;

endmodule

// File: design/dsdl_or_tree.sv
// ----------------------------------------------------------------------------
// dsdl_or_tree
// Registered radix-4 OR reduction of the cell probe outputs, with a register
// at each level.
// ----------------------------------------------------------------------------
module dsdl_or_tree #(
   parameter int LEAVES = 1024,
   parameter int WIDTH  = 59
) (
   input  logic             clock,
   input  logic [WIDTH-1:0] leaf [LEAVES],
   output logic [WIDTH-1:0] root
);
   localparam int LEVELS = ($clog2(LEAVES) + 1) / 2 > 0 ? ($clog2(LEAVES) + 1) / 2 : 1;
   localparam int PADDED = 1 << (2 * LEVELS);

   logic [WIDTH-1:0] base [PADDED];
   logic [WIDTH-1:0] node_ff [LEVELS][PADDED];

   for (genvar j = 0; j < PADDED; j++) begin : g_base
      if (j < LEAVES) begin : g_leaf
         assign base[j] = leaf[j];
      end else begin : g_pad
         assign base[j] = '0;
      end
   end

   for (genvar l = 0; l < LEVELS; l++) begin : g_level
      for (genvar j = 0; j < (PADDED >> (2 * (l + 1))); j++) begin : g_node
         if (l == 0) begin : g_first
            always_ff @(posedge clock) begin
               node_ff[l][j] <= base[4*j] | base[4*j+1] | base[4*j+2] | base[4*j+3];
            end
         end else begin : g_upper
            always_ff @(posedge clock) begin
               node_ff[l][j] <= node_ff[l-1][4*j] | node_ff[l-1][4*j+1]
                              | node_ff[l-1][4*j+2] | node_ff[l-1][4*j+3];
            end
         end
      end
   end

   assign root = node_ff[LEVELS-1][0];

endmodule

// File: dv/dsdl_checker.sv
// ----------------------------------------------------------------------------
// dsdl_checker
// Watches the request and response channels of the distance sorted draw list,
// keeps a shadow copy of the sorted list, predicts one response per request
// and compares each response field by field, in order.
// ----------------------------------------------------------------------------
module dsdl_checker
   import dsdl_pkg::*;
#(
   parameter int LIST_DEPTH = 1024
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      errors,
   output int      outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   entry_type   shadow_list [LIST_DEPTH];
   int unsigned shadow_count = 0;
   rsp_type     due_rsp [$];
   int          err_total = 0;

   function automatic rsp_type apply_to_shadow(req_type r);
      rsp_type     res;
      int unsigned slot;
      int unsigned i;
      res = '0;
      case (r.mode)
         MODE_CLEAR: begin
            shadow_count = 0;
         end
         MODE_INSERT: begin
            if (shadow_count < LIST_DEPTH) begin
               slot = shadow_count;
               for (i = 0; i < shadow_count; i++) begin
                  if (shadow_list[i].distance > r.distance) begin
                     slot = i;
                     break;
                  end
               end
               for (i = shadow_count; i > slot; i--)
                  shadow_list[i] = shadow_list[i-1];
               shadow_list[slot].item_kind  = r.item_kind;
               shadow_list[slot].item_index = r.item_index;
               shadow_list[slot].distance   = r.distance;
               shadow_list[slot].item_flags = r.item_flags;
               shadow_count++;
               res.accepted = 1'b1;
            end
         end
         MODE_LOOKUP: begin
            for (i = 0; i < shadow_count; i++) begin
               if (shadow_list[i].item_kind == r.item_kind &&
                   shadow_list[i].item_index == r.item_index) begin
                  res.found = 1'b1;
                  break;
               end
            end
         end
         default: begin
            if (r.position < shadow_count) begin
               res.read_valid    = 1'b1;
               res.read_kind     = shadow_list[r.position].item_kind;
               res.read_index    = shadow_list[r.position].item_index;
               res.read_distance = shadow_list[r.position].distance;
               res.read_flags    = shadow_list[r.position].item_flags;
            end
         end
      endcase
      res.entry_count = COUNT_OUT_W'(shadow_count);
      return res;
   endfunction

   task automatic check_field(string name, logic [DIST_W-1:0] want,
                              logic [DIST_W-1:0] got);
      if (want !== got) begin
         $display("%0t mismatch %s expected %0h actual %0h", $time, name, want, got);
         err_total++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         shadow_count = 0;
         due_rsp.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_rsp.size() == 0) begin
               $display("%0t unexpected response expected none actual %h", $time, rsp_data);
               err_total++;
            end else begin
               want = due_rsp.pop_front();
               check_field("accepted", DIST_W'(want.accepted), DIST_W'(rsp_data.accepted));
               check_field("found", DIST_W'(want.found), DIST_W'(rsp_data.found));
               check_field("entry_count", DIST_W'(want.entry_count),
                           DIST_W'(rsp_data.entry_count));
               check_field("read_valid", DIST_W'(want.read_valid),
                           DIST_W'(rsp_data.read_valid));
               check_field("read_kind", DIST_W'(want.read_kind), DIST_W'(rsp_data.read_kind));
               check_field("read_index", DIST_W'(want.read_index),
                           DIST_W'(rsp_data.read_index));
               check_field("read_distance", want.read_distance, rsp_data.read_distance);
               check_field("read_flags", DIST_W'(want.read_flags),
                           DIST_W'(rsp_data.read_flags));
            end
         end
         if (req_valid && !req_stall)
            due_rsp.push_back(apply_to_shadow(req_data));
      end
      errors      <= err_total;
      outstanding <= due_rsp.size();
   end

endmodule

// File: dv/distance_sorted_draw_list_tb.sv
// ----------------------------------------------------------------------------
// distance_sorted_draw_list_tb
// Drives clear, insert, lookup and read requests into the draw list with
// random gaps and response stalls: a directed opening, mixed random phases
// with many equal distances, and one phase that fills the list past full.
// ----------------------------------------------------------------------------
module distance_sorted_draw_list_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dsdl_pkg::*;

   localparam int LIST_DEPTH = 1024;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   int      errors;
   int      outstanding;

   logic    calm       = 1'b0;
   int      stall_hold = 0;
   int      held_guess = 0;

   distance_sorted_draw_list #(
      .LIST_DEPTH(LIST_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   dsdl_checker #(
      .LIST_DEPTH(LIST_DEPTH)
   ) list_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .errors(errors),
      .outstanding(outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("FAIL");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(0, 2);
      else if (r < 95)
         return $urandom_range(3, 8);
      else
         return $urandom_range(20, 40);
   endfunction

   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_stall  <= 1'b0;
         stall_hold <= 0;
      end else if (stall_hold > 0) begin
         stall_hold <= stall_hold - 1;
      end else begin
         rsp_stall  <= ($urandom_range(0, 99) < 40);
         stall_hold <= pick_gap();
      end
   end

   function automatic req_type make_req(logic [MODE_W-1:0] op, logic [TYPE_W-1:0] kind,
                                        logic [INDEX_W-1:0] idx, logic [DIST_W-1:0] key,
                                        logic [FLAGS_W-1:0] flg, logic [POS_W-1:0] pos);
      req_type r;
      r.mode       = op;
      r.item_kind  = kind;
      r.item_index = idx;
      r.distance   = key;
      r.item_flags = flg;
      r.position   = pos;
      return r;
   endfunction

   // small index and distance pools give lookup hits and equal distances
   function automatic req_type shaped_req(logic [MODE_W-1:0] op);
      req_type r;
      int      lim;
      r.mode       = op;
      r.item_kind  = TYPE_W'($urandom_range(0, 7));
      r.item_index = INDEX_W'($urandom_range(0, 1) ? $urandom_range(0, 7)
                                                    : $urandom_range(0, 32767));
      case ($urandom_range(0, 9))
         0:       r.distance = '0;
         1:       r.distance = '1;
         2, 3, 4: r.distance = $urandom_range(0, 15);
         default: r.distance = $urandom();
      endcase
      r.item_flags = FLAGS_W'($urandom_range(0, 255));
      lim = held_guess + 2;
      if (lim > 1023)
         lim = 1023;
      r.position = POS_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                       : $urandom_range(0, lim));
      return r;
   endfunction

   function automatic logic [MODE_W-1:0] pick_op();
      int r;
      r = $urandom_range(0, 99);
      if (r < 3)
         return MODE_CLEAR;
      else if (r < 50)
         return MODE_INSERT;
      else if (r < 75)
         return MODE_LOOKUP;
      else
         return MODE_READ;
   endfunction

   task automatic send(req_type r);
      int gap;
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      if (r.mode == MODE_CLEAR)
         held_guess = 0;
      else if (r.mode == MODE_INSERT && held_guess < LIST_DEPTH)
         held_guess++;
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (outstanding != 0);
   endtask

   initial begin
      int n;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed opening
      send(make_req(MODE_READ,   3'd0, 15'd0,     32'd0,         8'h00, 10'd0));
      send(make_req(MODE_LOOKUP, 3'd7, 15'h7fff,  32'd0,         8'h00, 10'd0));
      send(make_req(MODE_INSERT, 3'd3, 15'd100,   32'd500,       8'h5a, 10'd0));
      send(make_req(MODE_INSERT, 3'd7, 15'h7fff,  32'hffffffff,  8'hff, 10'd0));
      send(make_req(MODE_INSERT, 3'd0, 15'd0,     32'd0,         8'h00, 10'd0));
      send(make_req(MODE_INSERT, 3'd1, 15'd1,     32'd500,       8'h81, 10'd0));
      send(make_req(MODE_INSERT, 3'd2, 15'd2,     32'd0,         8'h01, 10'd0));
      for (int p = 0; p < 6; p++)
         send(make_req(MODE_READ, 3'd0, 15'd0, 32'd0, 8'h00, POS_W'(p)));
      send(make_req(MODE_LOOKUP, 3'd7, 15'h7fff,  32'd0,         8'h00, 10'd0));
      send(make_req(MODE_LOOKUP, 3'd7, 15'h7ffe,  32'd0,         8'h00, 10'd0));
      send(make_req(MODE_LOOKUP, 3'd3, 15'd100,   32'd0,         8'h00, 10'd0));
      send(make_req(MODE_READ,   3'd7, 15'h7fff,  32'hffffffff,  8'hff, 10'h3ff));
      send(make_req(MODE_INSERT, 3'd4, 15'h2aaa,  32'h55555555,  8'hc3, 10'h3ff));
      send(make_req(MODE_CLEAR,  3'd7, 15'h7fff,  32'hffffffff,  8'hff, 10'h3ff));
      send(make_req(MODE_READ,   3'd0, 15'd0,     32'd0,         8'h00, 10'd0));
      send(make_req(MODE_LOOKUP, 3'd0, 15'd0,     32'd0,         8'h00, 10'd0));
      send(make_req(MODE_INSERT, 3'd5, 15'd12345, 32'haaaaaaaa,  8'h55, 10'd0));
      send(make_req(MODE_READ,   3'd0, 15'd0,     32'd0,         8'h00, 10'd0));
      drain();

      // mixed phases, every fourth one without idling
      for (int ph = 0; ph < 12; ph++) begin
         calm <= (ph % 4 == 3);
         send(shaped_req(MODE_CLEAR));
         n = $urandom_range(40, 90);
         repeat (n) send(shaped_req(pick_op()));
         drain();
      end

      // fill the list, then push on it while full
      calm <= 1'b0;
      send(shaped_req(MODE_CLEAR));
      while (held_guess < LIST_DEPTH) begin
         if ($urandom_range(0, 9) < 8)
            send(shaped_req(MODE_INSERT));
         else
            send(shaped_req($urandom_range(0, 1) ? MODE_LOOKUP : MODE_READ));
      end
      send(make_req(MODE_READ, 3'd0, 15'd0, 32'd0, 8'h00, 10'h3ff));
      send(make_req(MODE_INSERT, 3'd6, 15'd9, 32'd0, 8'h11, 10'd0));
      repeat (40) send(shaped_req(MODE_W'($urandom_range(1, 3))));
      send(make_req(MODE_READ, 3'd0, 15'd0, 32'd0, 8'h00, 10'h3ff));
      send(shaped_req(MODE_CLEAR));
      send(make_req(MODE_READ, 3'd0, 15'd0, 32'd0, 8'h00, 10'h3ff));
      drain();

      repeat (10) @(posedge clock);
      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// File: filelist.f
design/dsdl_pkg.sv
design/dsdl_cell.sv
design/dsdl_or_tree.sv
design/distance_sorted_draw_list.sv
dv/dsdl_checker.sv
dv/distance_sorted_draw_list_tb.sv
